// File: rtl/izh_pkg.sv
// Shared types and fixed-point constants for the Izhikevich neuron step block.
`timescale 1ns / 1ps

package izh_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 15;

  typedef logic signed [WORD_W-1:0] word_t;

  // Fixed-point constants in s16.15.
  localparam word_t FX_140          = 32'sd4587520;
  localparam word_t FX_5            = 32'sd163840;
  localparam word_t FX_K            = 32'sd1311;
  localparam word_t FX_SPIKE_FACTOR = 32'sd60621;

  // Register reset values.
  localparam word_t RESET_A        = 32'sd655;
  localparam word_t RESET_B        = 32'sd6554;
  localparam word_t RESET_C        = -32'sd2129920;
  localparam word_t RESET_D        = 32'sd262144;
  localparam word_t RESET_OFFSET   = 32'sd0;
  localparam logic [30:0] RESET_TIMESTEP = 31'd32768;
  localparam logic [1:0]  RESET_NUM_EXC  = 2'd1;
  localparam logic [1:0]  RESET_NUM_INH  = 2'd1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMESTEP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_EXC  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_INH  = 3'd7;

  // Input operation codes.
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_SPIKE = 1'b1;

endpackage

// File: rtl/izh_fxmul.sv
// Registered signed s16.15 multiplier with truncation toward minus infinity.
`timescale 1ns / 1ps

module izh_fxmul (
  input  logic          clk,
  input  izh_pkg::word_t a,
  input  izh_pkg::word_t b,
  output izh_pkg::word_t prod
);
  import izh_pkg::*;

  logic signed [2*WORD_W-1:0] full;

  assign full = a * b;

  // An arithmetic shift right by the fraction width floors the result.
  always_ff @(posedge clk) begin
    prod <= full[FRAC_W+WORD_W-1:FRAC_W];
  end

endmodule

// File: rtl/izhikevich_neuron_rk2_step.sv
// Top level of the Izhikevich neuron: registers, sequencer and shared datapath.
`timescale 1ns / 1ps

// One neuron advanced by a midpoint (second-order) step in s16.15 fixed point.
// Step items run the update sequence, spike items the short path. The block is
// idle again in the cycle that loads the result, once the output is free, and
// takes no new item before it is through with the last. Over 27 sequencer steps
// a single registered multiplier and a single adder work through 12 products
// and 19 sums. The result sits in an output register, so the block goes on to
// the next item while the last result still waits to be taken. Configuration
// writes are always taken and must only come while idle.

module izhikevich_neuron_rk2_step (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [izh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [izh_pkg::WORD_W-1:0]      cfg_data,
  // Input items.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [159:0]                    s_tdata,  // exc_a, exc_b, inh_a, inh_b, bias
  input  logic                            s_tuser,  // op
  // Result items.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [izh_pkg::WORD_W-1:0]      m_tdata   // voltage
);
  import izh_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] ST_EXC     = 5'd1;
  localparam logic [ST_W-1:0] ST_INHA    = 5'd2;
  localparam logic [ST_W-1:0] ST_INHB    = 5'd3;
  localparam logic [ST_W-1:0] ST_BIAS    = 5'd4;
  localparam logic [ST_W-1:0] ST_OFFS    = 5'd5;
  localparam logic [ST_W-1:0] ST_C140    = 5'd6;
  localparam logic [ST_W-1:0] ST_PRE     = 5'd7;
  localparam logic [ST_W-1:0] ST_KV5     = 5'd8;
  localparam logic [ST_W-1:0] ST_POLYV   = 5'd9;
  localparam logic [ST_W-1:0] ST_ALPHA   = 5'd10;
  localparam logic [ST_W-1:0] ST_HALPHA  = 5'd11;
  localparam logic [ST_W-1:0] ST_BVU     = 5'd12;
  localparam logic [ST_W-1:0] ST_ETA     = 5'd13;
  localparam logic [ST_W-1:0] ST_BETAA   = 5'd14;
  localparam logic [ST_W-1:0] ST_BETA    = 5'd15;
  localparam logic [ST_W-1:0] ST_KETA    = 5'd16;
  localparam logic [ST_W-1:0] ST_KETA5   = 5'd17;
  localparam logic [ST_W-1:0] ST_POLYE   = 5'd18;
  localparam logic [ST_W-1:0] ST_VSUM0   = 5'd19;
  localparam logic [ST_W-1:0] ST_VSUM1   = 5'd20;
  localparam logic [ST_W-1:0] ST_VMUL    = 5'd21;
  localparam logic [ST_W-1:0] ST_VNEW    = 5'd22;
  localparam logic [ST_W-1:0] ST_UNEG    = 5'd23;
  localparam logic [ST_W-1:0] ST_UBETA   = 5'd24;
  localparam logic [ST_W-1:0] ST_UETA    = 5'd25;
  localparam logic [ST_W-1:0] ST_UMUL    = 5'd26;
  localparam logic [ST_W-1:0] ST_UNEW    = 5'd27;
  localparam logic [ST_W-1:0] ST_SPK     = 5'd28;
  localparam logic [ST_W-1:0] ST_SPKW    = 5'd29;
  localparam logic [ST_W-1:0] ST_DONE    = 5'd30;

  // Configuration registers.
  word_t       param_a, param_b, param_c, param_d, offset_current;
  logic [30:0] timestep;
  logic [1:0]  num_exc, num_inh;

  // Neuron state.
  word_t mem_v, rec_u, step_size;

  // Sequencer and working registers.
  logic [ST_W-1:0] state;
  logic [ST_W-1:0] state_next;
  word_t in_ea, in_eb, in_ia, in_ib, in_bias;
  word_t acc, t1, t2, t3, pre, eta, beta;

  // Shared units.
  word_t add_a, add_b, add_res;
  logic  add_sub;
  word_t mul_a, mul_b, prod;
  word_t timestep_w;
  logic  out_free;

  assign timestep_w = {1'b0, timestep};
  assign out_free   = !m_tvalid || m_tready;
  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == ST_IDLE);

  assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);

  izh_fxmul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Operand selection for the adder and the multiplier.
  always_comb begin
    add_a   = acc;
    add_b   = '0;
    add_sub = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state)
      ST_EXC: begin
        add_a = in_ea;  add_b = in_eb;
        mul_a = FX_K;   mul_b = mem_v;
      end
      ST_INHA: begin
        add_b = in_ia;  add_sub = 1'b1;
        mul_a = param_b; mul_b = mem_v;
      end
      ST_INHB: begin
        add_b = in_ib;  add_sub = 1'b1;
      end
      ST_BIAS:  add_b = in_bias;
      ST_OFFS:  add_b = offset_current;
      ST_C140:  add_b = FX_140;
      ST_PRE: begin
        add_b = rec_u;  add_sub = 1'b1;
      end
      ST_KV5: begin
        add_a = t1;     add_b = FX_5;
      end
      ST_POLYV: begin
        mul_a = t1;     mul_b = mem_v;
      end
      ST_ALPHA: begin
        add_a = pre;    add_b = prod;
      end
      ST_HALPHA: begin
        mul_a = step_size; mul_b = acc;
      end
      ST_BVU: begin
        add_a = t2;     add_b = rec_u;  add_sub = 1'b1;
      end
      ST_ETA: begin
        add_a = mem_v;  add_b = {t3[WORD_W-1], t3[WORD_W-1:1]};
        mul_a = step_size; mul_b = t2;
      end
      ST_BETAA: begin
        mul_a = prod;   mul_b = param_a;
      end
      ST_BETA: begin
        mul_a = FX_K;   mul_b = eta;
      end
      ST_KETA: begin
        mul_a = param_b; mul_b = eta;
      end
      ST_KETA5: begin
        add_a = t1;     add_b = FX_5;
      end
      ST_POLYE: begin
        mul_a = t1;     mul_b = eta;
      end
      ST_VSUM0: begin
        add_a = pre;    add_b = beta;   add_sub = 1'b1;
        mul_a = param_a; mul_b = step_size;
      end
      ST_VSUM1:  add_b = t1;
      ST_VMUL: begin
        mul_a = step_size; mul_b = acc;
      end
      ST_VNEW: begin
        add_a = mem_v;  add_b = prod;
      end
      ST_UNEG: begin
        add_a = '0;     add_b = rec_u;  add_sub = 1'b1;
      end
      ST_UBETA: begin
        add_b = beta;   add_sub = 1'b1;
      end
      ST_UETA:   add_b = t2;
      ST_UMUL: begin
        mul_a = t3;     mul_b = acc;
      end
      ST_UNEW: begin
        add_a = rec_u;  add_b = prod;
      end
      ST_SPK: begin
        mul_a = timestep_w; mul_b = FX_SPIKE_FACTOR;
      end
      ST_SPKW: begin
        add_a = rec_u;  add_b = param_d;
      end
      default: begin
        add_a = acc;
      end
    endcase
  end

  // Step order of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == OP_SPIKE) ? ST_SPK : ST_EXC;
        end
      end
      ST_UNEW: state_next = ST_DONE;
      ST_SPK:  state_next = ST_SPKW;
      ST_SPKW: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        if (state < ST_UNEW) begin
          state_next = state + 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Control state, configuration and neuron state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_tvalid       <= 1'b0;
      param_a        <= RESET_A;
      param_b        <= RESET_B;
      param_c        <= RESET_C;
      param_d        <= RESET_D;
      offset_current <= RESET_OFFSET;
      timestep       <= RESET_TIMESTEP;
      num_exc        <= RESET_NUM_EXC;
      num_inh        <= RESET_NUM_INH;
      mem_v          <= RESET_C;
      rec_u          <= '0;
      step_size      <= {1'b0, RESET_TIMESTEP};
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PARAM_A:  param_a        <= cfg_data;
          REG_PARAM_B:  param_b        <= cfg_data;
          REG_PARAM_C:  param_c        <= cfg_data;
          REG_PARAM_D:  param_d        <= cfg_data;
          REG_OFFSET:   offset_current <= cfg_data;
          REG_TIMESTEP: timestep       <= cfg_data[30:0];
          REG_NUM_EXC:  num_exc        <= cfg_data[1:0];
          REG_NUM_INH:  num_inh        <= cfg_data[1:0];
          default: begin
            param_a <= param_a;
          end
        endcase
      end
      case (state)
        ST_UNEW: begin
          mem_v     <= t1;
          rec_u     <= add_res;
          step_size <= timestep_w;
        end
        ST_SPKW: begin
          mem_v     <= param_c;
          rec_u     <= add_res;
          step_size <= prod;
        end
        default: begin
          mem_v <= mem_v;
        end
      endcase
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      // Inputs beyond the enabled count contribute nothing.
      in_ea   <= (num_exc != 2'd0) ? s_tdata[31:0]   : '0;
      in_eb   <= num_exc[1]        ? s_tdata[63:32]  : '0;
      in_ia   <= (num_inh != 2'd0) ? s_tdata[95:64]  : '0;
      in_ib   <= num_inh[1]        ? s_tdata[127:96] : '0;
      in_bias <= s_tdata[159:128];
    end
    case (state)
      ST_EXC, ST_INHA, ST_INHB, ST_BIAS, ST_OFFS, ST_C140, ST_ALPHA,
      ST_VSUM0, ST_VSUM1, ST_UNEG, ST_UBETA, ST_UETA: begin
        acc <= add_res;
      end
      default: begin
        acc <= acc;
      end
    endcase
    case (state)
      ST_INHA, ST_KETA, ST_VSUM0:  t1 <= prod;
      ST_KV5, ST_KETA5, ST_VNEW:   t1 <= add_res;
      default:                     t1 <= t1;
    endcase
    case (state)
      ST_INHB, ST_KETA5: t2 <= prod;
      ST_BVU:            t2 <= add_res;
      default:           t2 <= t2;
    endcase
    if (state == ST_BVU || state == ST_VSUM1) begin
      t3 <= prod;
    end
    if (state == ST_PRE) begin
      pre <= add_res;
    end
    if (state == ST_ETA) begin
      eta <= add_res;
    end
    if (state == ST_BETA) begin
      beta <= {prod[WORD_W-1], prod[WORD_W-1:1]};
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= mem_v;
    end
  end

  // A result is only loaded after a finished item.
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result appeared without a finished item");

  // An accepted spike item takes the short path.
  a_spike_path: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_SPIKE) |=> state == ST_SPK)
    else $error("spike item did not enter the spike path");

  // An accepted step item starts the current sum.
  a_step_path: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_STEP) |=> state == ST_EXC)
    else $error("step item did not start the update sequence");

  // A pending result is never overwritten before it is taken.
  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> state == ST_DONE)
    else $error("sequencer left the final step with the output full");

  // Neuron state changes only at the end of an item.
  a_state_commit: assert property (@(posedge clk) disable iff (rst)
    (state != ST_UNEW && state != ST_SPKW) |=> $stable(mem_v))
    else $error("membrane voltage changed outside the final step");

endmodule

// File: verif/izhikevich_neuron_rk2_step_tb.sv
// Self-checking testbench for the Izhikevich neuron midpoint step block.
`timescale 1ns / 1ps

module izhikevich_neuron_rk2_step_tb;
  import izh_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 48;
  localparam word_t SPIKE_PEAK  = 32'sd983040;  // 30 mV

  typedef struct {
    logic  op;
    word_t exc_a;
    word_t exc_b;
    word_t inh_a;
    word_t inh_b;
    word_t bias;
  } neuron_item_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    neuron_item_t        item;
    logic [CFG_IDX_W-1:0] reg_idx;
    word_t               reg_val;
    logic                typed;
    word_t               voltage;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [159:0] s_tdata;  // exc_a, exc_b, inh_a, inh_b, bias
  logic s_tuser;          // op
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;  // voltage

  izhikevich_neuron_rk2_step dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predicted registers and neuron state.
  word_t reg_a, reg_b, reg_c, reg_d, reg_offset;
  logic [30:0] reg_timestep;
  logic [1:0] reg_num_exc, reg_num_inh;
  word_t mem_v_q, rec_u_q, step_h_q;

  word_t voltage_due[$];
  stim_row_t script[$];
  int unsigned bad_results = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned spikes_sent = 0;
  int unsigned settings_used = 1;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int unsigned quiet_cycles = 0;
  int stall_left = 0;
  logic idling = 1'b1;

  // Product of two s16.15 values, floored back to s16.15 and wrapped to 32 bits.
  function automatic word_t fx_mul(input word_t x, input word_t y);
    logic signed [63:0] xl, yl, p;
    xl = x;
    yl = y;
    p = xl * yl;
    return p[46:15];
  endfunction

  function automatic word_t cubic_term(input word_t x);
    return fx_mul(FX_5 + fx_mul(FX_K, x), x);
  endfunction

  function automatic word_t advance_neuron(input neuron_item_t item);
    word_t exc, inh, cur, h, v, u, pre, alpha, eta, beta;
    if (item.op == OP_STEP) begin
      exc = '0;
      inh = '0;
      if (reg_num_exc >= 2'd1) exc = exc + item.exc_a;
      if (reg_num_exc >= 2'd2) exc = exc + item.exc_b;
      if (reg_num_inh >= 2'd1) inh = inh + item.inh_a;
      if (reg_num_inh >= 2'd2) inh = inh + item.inh_b;
      cur = exc - inh + item.bias + reg_offset;
      h = step_h_q;
      v = mem_v_q;
      u = rec_u_q;
      pre = FX_140 + cur - u;
      alpha = pre + cubic_term(v);
      eta = v + (fx_mul(h, alpha) >>> 1);
      beta = fx_mul(fx_mul(h, fx_mul(reg_b, v) - u), reg_a) >>> 1;
      mem_v_q = v + fx_mul(h, pre - beta + cubic_term(eta));
      rec_u_q = u + fx_mul(fx_mul(reg_a, h), -u - beta + fx_mul(reg_b, eta));
      step_h_q = {1'b0, reg_timestep};
    end else begin
      mem_v_q = reg_c;
      rec_u_q = rec_u_q + reg_d;
      step_h_q = fx_mul({1'b0, reg_timestep}, FX_SPIKE_FACTOR);
    end
    return mem_v_q;
  endfunction

  function automatic word_t pick_wide();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic neuron_item_t make_item(input bit wide);
    neuron_item_t item;
    if (wide) begin
      item.op = ($urandom_range(0, 4) == 0) ? OP_SPIKE : OP_STEP;
      item.exc_a = $urandom;
      item.exc_b = $urandom;
      item.inh_a = $urandom;
      item.inh_b = $urandom;
      item.bias = $urandom;
    end else begin
      // Fire once the membrane crosses the peak, as the surrounding network would, and now and then at random.
      item.op = (mem_v_q >= SPIKE_PEAK || $urandom_range(0, 49) == 0) ? OP_SPIKE : OP_STEP;
      item.exc_a = $urandom_range(0, 6 << 15);
      item.exc_b = $urandom_range(0, 6 << 15);
      item.inh_a = $urandom_range(0, 3 << 15);
      item.inh_b = $urandom_range(0, 3 << 15);
      item.bias = $urandom_range(0, 12 << 15);
    end
    return item;
  endfunction

  task automatic row_item(input logic op, input word_t ea, input word_t eb, input word_t ia,
                          input word_t ib, input word_t bi, input logic typed, input word_t v);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.item = '{op, ea, eb, ia, ib, bi};
    row.reg_idx = REG_PARAM_A;
    row.reg_val = '0;
    row.typed = typed;
    row.voltage = v;
    script.push_back(row);
  endtask

  task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.item = '{OP_STEP, '0, '0, '0, '0, '0};
    row.reg_idx = idx;
    row.reg_val = val;
    row.typed = 1'b0;
    row.voltage = '0;
    script.push_back(row);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PARAM_A:  reg_a = val;
      REG_PARAM_B:  reg_b = val;
      REG_PARAM_C:  reg_c = val;
      REG_PARAM_D:  reg_d = val;
      REG_OFFSET:   reg_offset = val;
      REG_TIMESTEP: reg_timestep = val[30:0];
      REG_NUM_EXC:  reg_num_exc = val[1:0];
      REG_NUM_INH:  reg_num_inh = val[1:0];
      default: ;
    endcase
  endtask

  // Registers may only change once the block has drained and gone idle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (voltage_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    settings_used++;
  endtask

  task automatic send_item(input neuron_item_t item, input logic typed, input word_t v);
    word_t predicted;
    cfg_valid <= 1'b0;
    if (idling && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= item.op;
    s_tdata <= {item.bias, item.inh_b, item.inh_a, item.exc_b, item.exc_a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = advance_neuron(item);
    voltage_due.push_back(typed ? v : predicted);
    items_sent++;
    if (item.op == OP_SPIKE) spikes_sent++;
  endtask

  task automatic load_config(input bit wide);
    word_t val [0:7];
    if (wide) begin
      for (int i = 0; i < 8; i++) val[i] = pick_wide();
    end else begin
      val[REG_PARAM_A] = $urandom_range(300, 3300);
      val[REG_PARAM_B] = $urandom_range(3000, 9000);
      val[REG_PARAM_C] = 32'sd0 - ($urandom_range(50, 70) << 15);
      val[REG_PARAM_D] = $urandom_range(0, 8 << 15);
      val[REG_OFFSET] = $urandom_range(0, 4 << 15);
      val[REG_TIMESTEP] = $urandom_range(8192, 65536);
      val[REG_NUM_EXC] = $urandom_range(0, 3);
      val[REG_NUM_INH] = $urandom_range(0, 3);
    end
    write_reg(REG_PARAM_A, val[REG_PARAM_A]);
    write_reg(REG_PARAM_B, val[REG_PARAM_B]);
    write_reg(REG_PARAM_C, val[REG_PARAM_C]);
    write_reg(REG_PARAM_D, val[REG_PARAM_D]);
    write_reg(REG_OFFSET, val[REG_OFFSET]);
    write_reg(REG_TIMESTEP, val[REG_TIMESTEP]);
    write_reg(REG_NUM_EXC, val[REG_NUM_EXC]);
    write_reg(REG_NUM_INH, val[REG_NUM_INH]);
  endtask

  // Result side: random back-pressure, one long hold-off on request, and checking.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (voltage_due.size() == 0) begin
          $display("%0t: voltage %h arrived with no expectation waiting", $time, m_tdata);
          bad_results++;
        end else begin
          if (m_tdata !== voltage_due[0]) begin
            $display("%0t: voltage mismatch: expected %h, actual %h",
                     $time, voltage_due[0], m_tdata);
            bad_results++;
          end
          void'(voltage_due.pop_front());
        end
      end
      if (stall_left == 0) begin
        if (hold_asked != hold_done) begin
          hold_done = hold_asked;
          stall_left = HOLD_CYCLES;
        end else if (idling && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 8);
        end
      end else begin
        stall_left--;
      end
      m_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    neuron_item_t item;
    bit wide;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= OP_STEP;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PARAM_A;
    cfg_data <= '0;

    reg_a = RESET_A;
    reg_b = RESET_B;
    reg_c = RESET_C;
    reg_d = RESET_D;
    reg_offset = RESET_OFFSET;
    reg_timestep = RESET_TIMESTEP;
    reg_num_exc = RESET_NUM_EXC;
    reg_num_inh = RESET_NUM_INH;
    mem_v_q = RESET_C;
    rec_u_q = '0;
    step_h_q = {1'b0, RESET_TIMESTEP};

    // Reset settings: spikes return c straight away, steps hit the input extremes.
    row_item(OP_SPIKE, 0, 0, 0, 0, 0, 1'b1, RESET_C);
    row_item(OP_STEP, 0, 0, 0, 0, 0, 1'b0, 0);
    row_item(OP_STEP, 32'h7FFF_FFFF, 0, 0, 0, 0, 1'b0, 0);
    row_item(OP_STEP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 1'b0, 0);
    row_item(OP_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 1'b0, 0);
    row_item(OP_SPIKE, 0, 0, 0, 0, 0, 1'b1, RESET_C);
    row_item(OP_STEP, 0, 0, 0, 0, 32'h000A_0000, 1'b0, 0);
    row_item(OP_SPIKE, 0, 0, 0, 0, 0, 1'b1, RESET_C);
    // Back-to-back spikes stack d onto u.
    row_item(OP_SPIKE, 32'hFFFF_FFFF, 0, 0, 0, 0, 1'b1, RESET_C);
    row_cfg(REG_NUM_EXC, 0);
    row_cfg(REG_NUM_INH, 0);
    row_item(OP_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 1'b0, 0);
    // A count of three behaves like two.
    row_cfg(REG_NUM_EXC, 3);
    row_cfg(REG_NUM_INH, 3);
    row_item(OP_STEP, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
             32'h0014_0000, 1'b0, 0);
    row_cfg(REG_NUM_EXC, 2);
    row_cfg(REG_NUM_INH, 2);
    row_item(OP_STEP, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 1'b0, 0);
    row_cfg(REG_PARAM_A, 32'h7FFF_FFFF);
    row_cfg(REG_PARAM_B, 32'h8000_0000);
    row_cfg(REG_PARAM_D, 32'h7FFF_FFFF);
    row_cfg(REG_OFFSET, 32'h8000_0000);
    row_item(OP_STEP, 0, 0, 0, 0, 0, 1'b0, 0);
    row_item(OP_SPIKE, 0, 0, 0, 0, 0, 1'b1, RESET_C);
    row_cfg(REG_PARAM_A, 32'h8000_0000);
    row_cfg(REG_PARAM_B, 32'h7FFF_FFFF);
    row_cfg(REG_PARAM_D, 32'h8000_0000);
    row_cfg(REG_OFFSET, 32'h7FFF_FFFF);
    row_cfg(REG_TIMESTEP, 32'h7FFF_FFFF);
    row_item(OP_STEP, 32'h0001_0000, 0, 0, 0, 0, 1'b0, 0);
    row_item(OP_SPIKE, 0, 0, 0, 0, 0, 1'b1, RESET_C);
    row_item(OP_STEP, 0, 0, 0, 0, 0, 1'b0, 0);
    // With a zero timestep the step size after a spike is zero, so v holds.
    row_cfg(REG_TIMESTEP, 0);
    row_cfg(REG_PARAM_C, 32'h8000_0000);
    row_item(OP_SPIKE, 0, 0, 0, 0, 0, 1'b1, 32'h8000_0000);
    row_item(OP_STEP, 32'h1234_5678, 0, 0, 0, 0, 1'b1, 32'h8000_0000);
    row_cfg(REG_PARAM_C, 32'h7FFF_FFFF);
    row_item(OP_SPIKE, 0, 0, 0, 0, 0, 1'b1, 32'h7FFF_FFFF);
    row_item(OP_STEP, 0, 0, 0, 0, 0, 1'b1, 32'h7FFF_FFFF);
    // Writing c alone must leave the stored membrane voltage untouched.
    row_cfg(REG_PARAM_C, 0);
    row_item(OP_STEP, 0, 0, 0, 0, 0, 1'b1, 32'h7FFF_FFFF);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        if (i == 0 || script[i-1].kind != ROW_CFG) wait_idle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_item(script[i].item, script[i].typed, script[i].voltage);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wide = (ph == 1 || ph == 3 || ph == 6);
      if (ph == NUM_PHASES - 1) idling <= 1'b0;
      wait_idle();
      load_config(wide);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 10) hold_asked <= hold_asked + 1;
        if (ph == 4 && n == 24) begin
          s_tvalid <= 1'b0;
          do @(posedge clk); while (voltage_due.size() != 0);
        end
        item = make_item(wide);
        // A realistic phase starts from a fresh spike so v is back near rest.
        if (!wide && n == 0) item.op = OP_SPIKE;
        send_item(item, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (voltage_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d spikes, %0d steps) across %0d register settings.",
             items_sent, spikes_sent, items_sent - spikes_sent, settings_used);
    $display("Checked %0d voltages, including a %0d-cycle output hold-off and a drained pause.",
             results_seen, HOLD_CYCLES);
    if (voltage_due.size() != 0)
      $display("%0t: %0d expected voltages never arrived", $time, voltage_due.size());
    if (bad_results == 0 && voltage_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: izhikevich_neuron_rk2_step.f
rtl/izh_pkg.sv
rtl/izh_fxmul.sv
rtl/izhikevich_neuron_rk2_step.sv
verif/izhikevich_neuron_rk2_step_tb.sv
